FILE: sv/lightmap_brightness_clamp_top_defines.svh
// Assertion macros used by the checker in lbc_checker.sv.
`ifndef LIGHTMAP_BRIGHTNESS_CLAMP_TOP_DEFINES_SVH
`define LIGHTMAP_BRIGHTNESS_CLAMP_TOP_DEFINES_SVH

// Generic clocked assertion, masked while reset is asserted.
`define LBC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the standard clock and reset names.
`define LBC_CHECK(lbl, prop, msg) \
  `LBC_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: sv/lbc_pkg.sv
package lbc_pkg;

  localparam int unsigned ChW      = 8;
  localparam int unsigned NumCh    = 3;
  localparam int unsigned NumCells = ChW;

  // Largest product (Q12.4) that still counts as 255.0.
  localparam logic [2*ChW-1:0] LimitQ4 = 16'd4080;
  // Gain after reset: 3.0 in Q4.4.
  localparam logic [ChW-1:0]   GainRst = 8'd48;

  // Channel order inside the lanes.
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  typedef logic [ChW-1:0] chan_t;

  // One division lane: partial remainder, and the remaining numerator bits
  // on top with the quotient bits shifting in from below.
  typedef struct packed {
    chan_t rem;
    chan_t nq;
  } div_lane_t;

  // What one cell hands to its neighbor.
  typedef struct packed {
    logic                   over;
    logic                   last;
    chan_t                  divisor;
    chan_t     [NumCh-1:0]  trunc;
    div_lane_t [NumCh-1:0]  lane;
  } cell_data_t;

endpackage

FILE: sv/lbc_in_if.sv
interface lbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       last_pixel_in;

  modport source (output valid, red_in, green_in, blue_in, last_pixel_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, last_pixel_in, output ready);
endinterface

FILE: sv/lbc_out_if.sv
interface lbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last_pixel_out;

  modport source (output valid, red_out, green_out, blue_out, last_pixel_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last_pixel_out, output ready);
endinterface

FILE: sv/lbc_prep.sv
module lbc_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic               last_i,
  input  logic [7:0]         gain_i,
  output logic               valid_o,
  input  logic               ready_i,
  output lbc_pkg::cell_data_t data_o
);
  import lbc_pkg::*;

  chan_t                ch    [NumCh];
  logic [2*ChW-1:0]     prod  [NumCh];
  logic [2*ChW-1:0]     numer [NumCh];
  chan_t                max01;
  cell_data_t           data_d;
  cell_data_t           data_q;
  logic                 valid_q;

  assign ch[ChRed]   = red_i;
  assign ch[ChGreen] = green_i;
  assign ch[ChBlue]  = blue_i;

  // Multiply by the gain, detect overflow, set up the divide by the max
  always_comb begin
    data_d      = '0;
    data_d.last = last_i;
    max01       = (ch[0] > ch[1]) ? ch[0] : ch[1];
    data_d.divisor = (max01 > ch[2]) ? max01 : ch[2];
    for (int k = 0; k < NumCh; k++) begin
      prod[k]  = {{ChW{1'b0}}, ch[k]} * {{ChW{1'b0}}, gain_i};
      numer[k] = {ch[k], {ChW{1'b0}}} - {{ChW{1'b0}}, ch[k]};
      if (prod[k] > LimitQ4) begin
        data_d.over = 1'b1;
      end
      data_d.trunc[k]    = prod[k][ChW+3:4];
      data_d.lane[k].rem = numer[k][2*ChW-1:ChW];
      data_d.lane[k].nq  = numer[k][ChW-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Advance the stage whenever it is empty or the next one can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/lbc_cell.sv
module lbc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  lbc_pkg::cell_data_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output lbc_pkg::cell_data_t data_o
);
  import lbc_pkg::*;

  cell_data_t data_d;
  cell_data_t data_q;
  logic       valid_q;

  // One restoring step: bring down a numerator bit, subtract if it fits
  function automatic div_lane_t div_step(div_lane_t l, chan_t d);
    logic [ChW:0] r9;
    logic         fits;
    logic [ChW:0] diff;
    div_lane_t    res;
    r9      = {l.rem, l.nq[ChW-1]};
    fits    = (r9 >= {1'b0, d});
    diff    = r9 - {1'b0, d};
    res.rem = fits ? diff[ChW-1:0] : r9[ChW-1:0];
    res.nq  = {l.nq[ChW-2:0], fits};
    return res;
  endfunction

  always_comb begin
    data_d = data_i;
    for (int k = 0; k < NumCh; k++) begin
      data_d.lane[k] = div_step(data_i.lane[k], data_i.divisor);
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Hand the request on to the neighbor, or hold it while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/lightmap_brightness_clamp_top.sv
// Channel   | Dir | Handshake           | Payload
// pix_i     | in  | valid/ready         | red_in, green_in, blue_in, last_pixel_in
// pix_o     | out | valid/ready         | red_out, green_out, blue_out, last_pixel_out
// gain      | in  | gain_we_i (no wait) | gain_wdata_i, Q4.4
//
// One pixel taken per cycle unless stalled; it passes the multiply stage,
// eight divider cells and the output register, one quotient bit per cell.
// Each stage stalls only when it holds a request its neighbor cannot take,
// so bubbles close up and the input keeps flowing while a result waits.
// Reset empties every stage and loads the gain with 3.0.
module lightmap_brightness_clamp_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbc_in_if.sink     pix_i,
  lbc_out_if.source  pix_o,
  input  logic       gain_we_i,
  input  logic [7:0] gain_wdata_i
);
  import lbc_pkg::*;

  chan_t      gain_q;
  logic       valid  [NumCells+1];
  logic       ready  [NumCells+1];
  cell_data_t data   [NumCells+1];
  cell_data_t fin;
  chan_t      res_d  [NumCh];
  chan_t      res_q  [NumCh];
  logic       last_q;
  logic       out_valid_q;
  logic       out_ready;

  // Hold the gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainRst;
    end else if (gain_we_i) begin
      gain_q <= gain_wdata_i;
    end
  end

  lbc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .red_i   (pix_i.red_in),
    .green_i (pix_i.green_in),
    .blue_i  (pix_i.blue_in),
    .last_i  (pix_i.last_pixel_in),
    .gain_i  (gain_q),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .data_o  (data[0])
  );

  // Divider chain, one quotient bit per cell
  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    lbc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[c]),
      .ready_o (ready[c]),
      .data_i  (data[c]),
      .valid_o (valid[c+1]),
      .ready_i (ready[c+1]),
      .data_o  (data[c+1])
    );
  end

  assign fin = data[NumCells];

  // Pick the scaled quotient on overflow, else the truncated product
  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      res_d[k] = fin.over ? fin.lane[k].nq : fin.trunc[k];
    end
  end

  assign out_ready         = !out_valid_q || pix_o.ready;
  assign ready[NumCells]   = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= valid[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && valid[NumCells]) begin
      for (int k = 0; k < NumCh; k++) begin
        res_q[k] <= res_d[k];
      end
      last_q <= fin.last;
    end
  end

  assign pix_o.valid          = out_valid_q;
  assign pix_o.red_out        = res_q[ChRed];
  assign pix_o.green_out      = res_q[ChGreen];
  assign pix_o.blue_out       = res_q[ChBlue];
  assign pix_o.last_pixel_out = last_q;

endmodule

FILE: sv/lbc_checker.sv
`include "lightmap_brightness_clamp_top_defines.svh"

module lbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic       last_i
);

  logic        out_stall;
  logic [24:0] out_pix;

  assign out_stall = out_valid_i && !out_ready_i;
  assign out_pix   = {red_i, green_i, blue_i, last_i};

  // A stalled result stays offered with the same pixel
  `LBC_CHECK(a_out_hold, out_stall |=> out_valid_i && $stable(out_pix), "stalled result changed")

  // An empty output register never blocks new pixels
  `LBC_CHECK(a_empty_takes, !out_valid_i |-> in_ready_i, "input blocked with empty output")

  // A result offered at the output is only withdrawn after it was taken
  `LBC_CHECK(a_out_drop, $fell(out_valid_i) |-> $past(out_ready_i), "result withdrawn untaken")

  // No pixel in flight means nothing may show up right away
  `LBC_CHECK(a_no_spurious, $rose(rst_ni) |-> !out_valid_i, "result right after reset")

endmodule

bind lightmap_brightness_clamp_top lbc_checker u_lbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .red_i       (pix_o.red_out),
  .green_i     (pix_o.green_out),
  .blue_i      (pix_o.blue_out),
  .last_i      (pix_o.last_pixel_out)
);

FILE: dv/lbc_pixel_checker.sv
`timescale 1ns / 1ps
// Watches the pixel channels and the gain port, predicts every brightened
// pixel and compares it with what the block hands out.
module lbc_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbc_in_if           pix_i,
  lbc_out_if          pix_o,
  input  logic        gain_we_i,
  input  logic [7:0]  gain_wdata_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  import lbc_pkg::*;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } pixel_t;

  chan_t       gain_q;
  pixel_t      expected_pixels[$];
  int unsigned mismatches;

  // Overflowing pixels are rescaled so the brightest channel lands on 255,
  // otherwise the Q12.4 product is truncated to its integer part.
  function automatic pixel_t brighten_pixel(pixel_t px, chan_t gain);
    logic [15:0] prod[NumCh];
    chan_t       chan[NumCh];
    chan_t       res[NumCh];
    chan_t       peak;
    logic        over;
    pixel_t      result;
    chan[ChRed]   = px.red;
    chan[ChGreen] = px.green;
    chan[ChBlue]  = px.blue;
    over = 1'b0;
    peak = '0;
    for (int i = 0; i < NumCh; i++) begin
      prod[i] = 16'(chan[i]) * 16'(gain);
      if (prod[i] > LimitQ4) over = 1'b1;
      if (chan[i] > peak) peak = chan[i];
    end
    for (int i = 0; i < NumCh; i++) begin
      if (over && peak != 0) begin
        res[i] = 8'((16'd255 * 16'(chan[i])) / 16'(peak));
      end else if (over) begin
        res[i] = '0;
      end else begin
        res[i] = prod[i][11:4];
      end
    end
    result.red   = res[ChRed];
    result.green = res[ChGreen];
    result.blue  = res[ChBlue];
    result.last  = px.last;
    return result;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Check results, queue predictions, then track the gain register.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_t want;
    pixel_t seen;
    if (!rst_ni) begin
      gain_q = GainRst;
      expected_pixels.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (pix_o.valid && pix_o.ready) begin
        seen = '{pix_o.red_out, pix_o.green_out, pix_o.blue_out, pix_o.last_pixel_out};
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel: red %0d green %0d blue %0d last %0d",
                 seen.red, seen.green, seen.blue, seen.last);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red_out", want.red, seen.red);
          check_field("green_out", want.green, seen.green);
          check_field("blue_out", want.blue, seen.blue);
          check_field("last_pixel_out", want.last, seen.last);
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        want = brighten_pixel('{pix_i.red_in, pix_i.green_in, pix_i.blue_in,
                                pix_i.last_pixel_in}, gain_q);
        expected_pixels.insert(expected_pixels.size(), want);
      end
      if (gain_we_i) gain_q = gain_wdata_i;
      mismatch_count_o <= mismatches;
      pending_o <= expected_pixels.size();
    end
  end

endmodule

FILE: dv/tb_lightmap_brightness_clamp_top.sv
`timescale 1ns / 1ps
module tb_lightmap_brightness_clamp_top;
  import lbc_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned NumPhases   = 12;
  localparam int unsigned PhaseItems  = 135;
  localparam int unsigned IdlePct     = 37;
  localparam int unsigned QuietPhase  = 5;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        gain_we;
  logic [7:0]  gain_wdata;
  chan_t       cur_gain;
  int unsigned gap_pct = IdlePct;
  int unsigned stall_pct = IdlePct;
  int unsigned cycle_count = 0;
  int unsigned mismatches;
  int unsigned pending;

  lbc_in_if  pix_in();
  lbc_out_if pix_out();

  lightmap_brightness_clamp_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_in),
    .pix_o        (pix_out),
    .gain_we_i    (gain_we),
    .gain_wdata_i (gain_wdata)
  );

  lbc_pixel_checker pixel_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pix_i            (pix_in),
    .pix_o            (pix_out),
    .gain_we_i        (gain_we),
    .gain_wdata_i     (gain_wdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always #6 clk_i = ~clk_i;

  // Stall the result side at random.
  always @(posedge clk_i) begin
    pix_out.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** lightmap_brightness_clamp_top: FAILED **");
      $finish;
    end
  end

  // Hold a pixel request until it is taken, after a random gap.
  task automatic send_pixel(chan_t red, chan_t green, chan_t blue, logic last);
    while ($urandom_range(99) < gap_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid         <= 1'b1;
    pix_in.red_in        <= red;
    pix_in.green_in      <= green;
    pix_in.blue_in       <= blue;
    pix_in.last_pixel_in <= last;
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  // Drop valid and wait until every predicted pixel has come out.
  task automatic drain_results();
    pix_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Channel value just around the point where the product passes 255.0.
  function automatic chan_t near_limit(chan_t gain);
    int unsigned knee;
    knee = (gain == 0) ? 255 : 4080 / gain;
    if (knee > 254) knee = 254;
    if (knee < 1) knee = 1;
    return chan_t'(knee - 1 + $urandom_range(2));
  endfunction

  initial begin
    chan_t       red;
    chan_t       green;
    chan_t       blue;
    chan_t       level;
    chan_t       gain_list[6];
    gain_list = '{8'd0, 8'd255, 8'd16, 8'd1, 8'd17, GainRst};
    rst_ni = 1'b0;
    pix_in.valid         <= 1'b0;
    pix_in.red_in        <= '0;
    pix_in.green_in      <= '0;
    pix_in.blue_in       <= '0;
    pix_in.last_pixel_in <= 1'b0;
    gain_we              <= 1'b0;
    gain_wdata           <= '0;
    cur_gain = GainRst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels at the reset gain of 3.0: 85 lands exactly on 255.0.
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd85, 8'd85, 8'd85, 1'b0);
    send_pixel(8'd86, 8'd85, 8'd0, 1'b0);
    send_pixel(8'd84, 8'd85, 8'd85, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b0);
    send_pixel(8'd170, 8'd85, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd254, 8'd253, 1'b1);
    send_pixel(8'd128, 8'd64, 8'd32, 1'b0);
    send_pixel(8'd86, 8'd1, 8'd43, 1'b0);
    send_pixel(8'd0, 8'd86, 8'd0, 1'b1);

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      // Load a new gain while the pipeline is empty.
      cur_gain = (phase < 6) ? gain_list[phase] : chan_t'($urandom_range(255));
      gain_we    <= 1'b1;
      gain_wdata <= cur_gain;
      @(posedge clk_i);
      gain_we    <= 1'b0;
      gap_pct   = (phase == QuietPhase) ? 0 : IdlePct;
      stall_pct = (phase == QuietPhase) ? 0 : IdlePct;

      for (int n = 0; n < PhaseItems; n++) begin
        case ($urandom_range(3))
          0: begin
            red   = chan_t'($urandom_range(255));
            green = chan_t'($urandom_range(255));
            blue  = chan_t'($urandom_range(255));
          end
          1: begin
            level = near_limit(cur_gain);
            red   = chan_t'($urandom_range(level));
            green = chan_t'($urandom_range(level));
            blue  = chan_t'($urandom_range(level));
            case ($urandom_range(2))
              0: red   = level;
              1: green = level;
              default: blue = level;
            endcase
          end
          2: begin
            level = $urandom_range(1) ? near_limit(cur_gain) : chan_t'($urandom_range(255));
            red   = level;
            green = level;
            blue  = level;
          end
          default: begin
            red   = chan_t'($urandom_range(15));
            green = chan_t'($urandom_range(15));
            blue  = chan_t'($urandom_range(15));
          end
        endcase
        send_pixel(red, green, blue, $urandom_range(7) == 0);
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** lightmap_brightness_clamp_top: PASSED **");
    end else begin
      $display("** lightmap_brightness_clamp_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/lbc_pkg.sv
sv/lbc_in_if.sv
sv/lbc_out_if.sv
sv/lbc_prep.sv
sv/lbc_cell.sv
sv/lightmap_brightness_clamp_top.sv
sv/lbc_checker.sv
dv/lbc_pixel_checker.sv
dv/tb_lightmap_brightness_clamp_top.sv
